@@ design/peak_rms_power_energy_meter_assert.svh @@
// assertion macros for the peak rms power energy meter
`ifndef PEAK_RMS_POWER_ENERGY_METER_ASSERT_SVH
`define PEAK_RMS_POWER_ENERGY_METER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/prm_pkg.sv @@
package prm_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int WIN_DIV_W   = 9;
    localparam int DVD_W       = 48;

    localparam int SECONDS_PER_HOUR_DEF = 3600;
    localparam int ADC_BITS_DEF         = 12;

    localparam logic [23:0] VOLTAGE_GAIN_RST       = 24'd18652;
    localparam logic [30:0] VOLTAGE_OFFSET_RST     = 31'd37970000;
    localparam logic [23:0] CURRENT_GAIN_RST       = 24'd598;
    localparam logic [30:0] CURRENT_OFFSET_RST     = 31'd1233170;
    localparam logic [15:0] WINDOW_LEN_RST         = 16'd400;
    localparam logic [7:0]  WINDOWS_PER_REPORT_RST = 8'd50;
    localparam logic [9:0]  MIN_VOLTAGE_RST        = 10'd65;
    localparam logic [9:0]  POWER_GATE_RST         = 10'd180;

    typedef struct packed {
        logic [SAMPLE_W-1:0] voltage_sample;
        logic [SAMPLE_W-1:0] current_sample;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] voltage_rms;
        logic signed [31:0] current_rms;
        logic signed [47:0] power;
        logic signed [63:0] energy;
    } report_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLTAGE_GAIN,
        REG_VOLTAGE_OFFSET,
        REG_CURRENT_GAIN,
        REG_CURRENT_OFFSET,
        REG_WINDOW_LEN,
        REG_WINDOWS_PER_REPORT,
        REG_MIN_VOLTAGE,
        REG_POWER_GATE
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EST_MUL,
        S_EST_ACC,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_DIV_DONE,
        S_PWR_MUL,
        S_PWR,
        S_ENERGY,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        DIV_VOLT,
        DIV_CURR,
        DIV_ENERGY
    } div_sel_t;

endpackage

@@ design/peak_rms_power_energy_meter.sv @@
// Peak-detecting RMS, power and energy meter. A sample beat that does not close a window
// is taken while the meter stays idle. On the closing beat of a window the shared
// multiplier forms gain*peak for each channel in turn, and each estimate is added to its
// saturating sum. A window that also closes a report then runs the following steps. One
// shared bit-per-cycle divider runs three times (a load, 48 shift steps and a finish each):
// voltage average, current average, then power/SECONDS_PER_HOUR. Between the second and
// third runs the multiplier forms power in S_PWR_MUL and S_PWR; then come an energy step
// and an emit step. The emit step waits while an earlier report is still held. Sample
// stall stays high while any of this runs. The report sits in an output register, so a
// new sample beat is accepted while it waits to be taken.
`include "peak_rms_power_energy_meter_assert.svh"

module peak_rms_power_energy_meter #(
    parameter int SECONDS_PER_HOUR = prm_pkg::SECONDS_PER_HOUR_DEF,
    parameter int ADC_BITS         = prm_pkg::ADC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [prm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [prm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  prm_pkg::sample_t                    sample,
    output logic                                report_valid,
    input  logic                                report_stall,
    output prm_pkg::report_t                    report
);
    import prm_pkg::*;

    localparam int SPH_W     = $clog2(SECONDS_PER_HOUR + 1);
    localparam int DSR_W     = (SPH_W > WIN_DIV_W) ? SPH_W : WIN_DIV_W;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam logic [SAMPLE_W-1:0] ADC_MASK = (ADC_BITS >= SAMPLE_W) ? '1 :
        SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);

    // configuration
    logic [23:0] voltage_gain_reg;
    logic [30:0] voltage_offset_reg;
    logic [23:0] current_gain_reg;
    logic [30:0] current_offset_reg;
    logic [15:0] window_len_reg;
    logic [7:0]  windows_per_report_reg;
    logic [9:0]  min_voltage_reg;
    logic [9:0]  power_gate_reg;

    // control
    state_t   state_reg, state_next;
    logic     ch_reg, ch_next;
    div_sel_t div_sel_reg, div_sel_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic     report_valid_reg, report_valid_next;

    // meter state
    logic [15:0]         sample_count_reg, sample_count_next;
    logic [SAMPLE_W-1:0] vpeak_reg, vpeak_next;
    logic [SAMPLE_W-1:0] cpeak_reg, cpeak_next;
    logic [7:0]          window_count_reg, window_count_next;
    logic signed [39:0]  vsum_reg, vsum_next;
    logic signed [39:0]  csum_reg, csum_next;
    logic signed [63:0]  energy_reg, energy_next;

    // datapath
    logic [DVD_W-1:0]    quo_reg, quo_next;
    logic [DSR_W-1:0]    rem_reg, rem_next;
    logic [DSR_W-1:0]    dsr_reg, dsr_next;
    logic                neg_reg, neg_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic signed [31:0]  v_avg_reg, v_avg_next;
    logic signed [31:0]  c_avg_reg, c_avg_next;
    logic                gate_reg, gate_next;
    logic signed [47:0]  p_reg, p_next;
    logic signed [47:0]  step_reg, step_next;
    report_t             report_reg, report_next;

    logic sample_accept;
    logic out_free;
    logic [SAMPLE_W-1:0] vs, cs, vpeak_upd, cpeak_upd;
    logic count_open;
    logic win_open;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [38:0] est_raw;
    logic signed [31:0] est;
    logic signed [40:0] sum_raw;
    logic signed [39:0] sum_sat;
    logic signed [39:0] sum_cur;
    logic signed [DVD_W-1:0] dvd;
    logic [DSR_W:0]     rem_shift;
    logic               rem_ge;
    logic signed [DVD_W-1:0] quo_signed;
    logic signed [64:0] energy_raw;

    assign sample_stall  = (state_reg != S_IDLE);
    assign sample_accept = sample_valid && !sample_stall;
    assign out_free      = !report_valid_reg || !report_stall;
    assign report_valid  = report_valid_reg;
    assign report        = report_reg;

    assign vs = sample.voltage_sample & ADC_MASK;
    assign cs = sample.current_sample & ADC_MASK;
    assign vpeak_upd = (vs > vpeak_reg) ? vs : vpeak_reg;
    assign cpeak_upd = (cs > cpeak_reg) ? cs : cpeak_reg;
    assign count_open = (sample_count_reg < window_len_reg);
    assign win_open   = (window_count_reg < windows_per_report_reg);

    // shared multiplier
    always_comb
    begin
        if (state_reg == S_PWR_MUL)
        begin
            mul_a = 33'(v_avg_reg);
            mul_b = 33'(c_avg_reg);
        end
        else if (ch_reg)
        begin
            mul_a = $signed({9'b0, current_gain_reg});
            mul_b = $signed({21'b0, cpeak_reg});
        end
        else
        begin
            mul_a = $signed({9'b0, voltage_gain_reg});
            mul_b = $signed({21'b0, vpeak_reg});
        end
        mul_p = 66'(mul_a) * 66'(mul_b);
    end

    // estimate and saturating sum
    always_comb
    begin
        if (ch_reg)
            est_raw = $signed({2'b0, prod_reg[36:0]}) - $signed({8'b0, current_offset_reg});
        else
            est_raw = $signed({2'b0, prod_reg[36:0]}) - $signed({8'b0, voltage_offset_reg});
        if (est_raw > 39'sd2147483647)
            est = 32'sh7FFF_FFFF;
        else if (est_raw < -39'sd2147483648)
            est = 32'sh8000_0000;
        else
            est = est_raw[31:0];
        sum_cur = ch_reg ? csum_reg : vsum_reg;
        sum_raw = 41'(sum_cur) + 41'(est);
        if (sum_raw > 41'sd549755813887)
            sum_sat = 40'sh7F_FFFF_FFFF;
        else if (sum_raw < -41'sd549755813888)
            sum_sat = 40'sh80_0000_0000;
        else
            sum_sat = sum_raw[39:0];
    end

    // divider step and result sign
    always_comb
    begin
        unique case (div_sel_reg)
            DIV_VOLT:   dvd = DVD_W'(vsum_reg);
            DIV_CURR:   dvd = DVD_W'(csum_reg);
            DIV_ENERGY: dvd = p_reg;
            default:    dvd = p_reg;
        endcase
        rem_shift  = {rem_reg, quo_reg[DVD_W-1]};
        rem_ge     = (rem_shift >= {1'b0, dsr_reg});
        quo_signed = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
        energy_raw = 65'(energy_reg) + 65'(step_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (sample_accept && !count_open)
                    state_next = S_EST_MUL;
            S_EST_MUL:
                state_next = S_EST_ACC;
            S_EST_ACC:
                if (!ch_reg)
                    state_next = S_EST_MUL;
                else if (win_open)
                    state_next = S_IDLE;
                else
                    state_next = S_DIV_LOAD;
            S_DIV_LOAD:
                state_next = S_DIV_RUN;
            S_DIV_RUN:
                if (div_cnt_reg == DIV_CNT_W'(DVD_W - 1))
                    state_next = S_DIV_DONE;
            S_DIV_DONE:
                unique case (div_sel_reg)
                    DIV_VOLT:   state_next = S_DIV_LOAD;
                    DIV_CURR:   state_next = S_PWR_MUL;
                    DIV_ENERGY: state_next = S_ENERGY;
                    default:    state_next = S_ENERGY;
                endcase
            S_PWR_MUL:
                state_next = S_PWR;
            S_PWR:
                state_next = S_DIV_LOAD;
            S_ENERGY:
                state_next = S_EMIT;
            S_EMIT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ch_next           = ch_reg;
        div_sel_next      = div_sel_reg;
        div_cnt_next      = div_cnt_reg;
        sample_count_next = sample_count_reg;
        vpeak_next        = vpeak_reg;
        cpeak_next        = cpeak_reg;
        window_count_next = window_count_reg;
        vsum_next         = vsum_reg;
        csum_next         = csum_reg;
        energy_next       = energy_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        dsr_next          = dsr_reg;
        neg_next          = neg_reg;
        prod_next         = prod_reg;
        v_avg_next        = v_avg_reg;
        c_avg_next        = c_avg_reg;
        gate_next         = gate_reg;
        p_next            = p_reg;
        step_next         = step_reg;
        report_next       = report_reg;
        report_valid_next = report_valid_reg;

        if (report_valid_reg && !report_stall)
            report_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
                if (sample_accept)
                begin
                    vpeak_next = vpeak_upd;
                    cpeak_next = cpeak_upd;
                    ch_next    = 1'b0;
                    if (count_open)
                        sample_count_next = sample_count_reg + 16'd1;
                    else
                        sample_count_next = '0;
                end
            S_EST_MUL:
                prod_next = mul_p[63:0];
            S_EST_ACC:
                if (!ch_reg)
                begin
                    vsum_next = sum_sat;
                    ch_next   = 1'b1;
                end
                else
                begin
                    csum_next    = sum_sat;
                    vpeak_next   = '0;
                    cpeak_next   = '0;
                    div_sel_next = DIV_VOLT;
                    if (win_open)
                        window_count_next = window_count_reg + 8'd1;
                end
            S_DIV_LOAD:
            begin
                neg_next     = dvd[DVD_W-1];
                quo_next     = dvd[DVD_W-1] ? DVD_W'(-dvd) : DVD_W'(dvd);
                rem_next     = '0;
                div_cnt_next = '0;
                if (div_sel_reg == DIV_ENERGY)
                    dsr_next = DSR_W'(SECONDS_PER_HOUR);
                else
                    dsr_next = DSR_W'({1'b0, window_count_reg} + 9'd1);
            end
            S_DIV_RUN:
            begin
                rem_next     = rem_ge ? DSR_W'(rem_shift - {1'b0, dsr_reg})
                                      : DSR_W'(rem_shift);
                quo_next     = {quo_reg[DVD_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            end
            S_DIV_DONE:
                unique case (div_sel_reg)
                    DIV_VOLT:
                    begin
                        // low voltage reads as zero
                        if ($signed(quo_signed[31:0]) < $signed({6'b0, min_voltage_reg, 16'b0}))
                            v_avg_next = '0;
                        else
                            v_avg_next = quo_signed[31:0];
                        div_sel_next = DIV_CURR;
                    end
                    DIV_CURR:
                        c_avg_next = quo_signed[31:0];
                    DIV_ENERGY:
                        step_next = quo_signed;
                    default:
                        step_next = quo_signed;
                endcase
            S_PWR_MUL:
            begin
                prod_next = mul_p[63:0];
                gate_next = (v_avg_reg > $signed({6'b0, power_gate_reg, 16'b0}));
            end
            S_PWR:
            begin
                // product stays below 2^62, so the top 48 bits are the floored shift
                p_next       = gate_reg ? prod_reg[63:16] : '0;
                div_sel_next = DIV_ENERGY;
            end
            S_ENERGY:
            begin
                if (energy_raw > 65'sh0_7FFF_FFFF_FFFF_FFFF)
                    energy_next = 64'sh7FFF_FFFF_FFFF_FFFF;
                else if (energy_raw < -65'sh0_8000_0000_0000_0000)
                    energy_next = 64'sh8000_0000_0000_0000;
                else
                    energy_next = energy_raw[63:0];
                vsum_next         = '0;
                csum_next         = '0;
                window_count_next = '0;
            end
            S_EMIT:
                if (out_free)
                begin
                    report_next.voltage_rms = v_avg_reg;
                    report_next.current_rms = c_avg_reg;
                    report_next.power       = p_reg;
                    report_next.energy      = energy_reg;
                    report_valid_next       = 1'b1;
                end
            default:
                ch_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voltage_gain_reg       <= VOLTAGE_GAIN_RST;
            voltage_offset_reg     <= VOLTAGE_OFFSET_RST;
            current_gain_reg       <= CURRENT_GAIN_RST;
            current_offset_reg     <= CURRENT_OFFSET_RST;
            window_len_reg         <= WINDOW_LEN_RST;
            windows_per_report_reg <= WINDOWS_PER_REPORT_RST;
            min_voltage_reg        <= MIN_VOLTAGE_RST;
            power_gate_reg         <= POWER_GATE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_VOLTAGE_GAIN:       voltage_gain_reg       <= cfg_data[23:0];
                REG_VOLTAGE_OFFSET:     voltage_offset_reg     <= cfg_data[30:0];
                REG_CURRENT_GAIN:       current_gain_reg       <= cfg_data[23:0];
                REG_CURRENT_OFFSET:     current_offset_reg     <= cfg_data[30:0];
                REG_WINDOW_LEN:         window_len_reg         <= cfg_data[15:0];
                REG_WINDOWS_PER_REPORT: windows_per_report_reg <= cfg_data[7:0];
                REG_MIN_VOLTAGE:        min_voltage_reg        <= cfg_data[9:0];
                REG_POWER_GATE:         power_gate_reg         <= cfg_data[9:0];
                default:                power_gate_reg         <= power_gate_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ch_reg           <= 1'b0;
            div_sel_reg      <= DIV_VOLT;
            div_cnt_reg      <= '0;
            report_valid_reg <= 1'b0;
            sample_count_reg <= '0;
            vpeak_reg        <= '0;
            cpeak_reg        <= '0;
            window_count_reg <= '0;
            vsum_reg         <= '0;
            csum_reg         <= '0;
            energy_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            ch_reg           <= ch_next;
            div_sel_reg      <= div_sel_next;
            div_cnt_reg      <= div_cnt_next;
            report_valid_reg <= report_valid_next;
            sample_count_reg <= sample_count_next;
            vpeak_reg        <= vpeak_next;
            cpeak_reg        <= cpeak_next;
            window_count_reg <= window_count_next;
            vsum_reg         <= vsum_next;
            csum_reg         <= csum_next;
            energy_reg       <= energy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dsr_reg    <= dsr_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        v_avg_reg  <= v_avg_next;
        c_avg_reg  <= c_avg_next;
        gate_reg   <= gate_next;
        p_reg      <= p_next;
        step_reg   <= step_next;
        report_reg <= report_next;
    end

    `PRM_ASSERT_NEXT(a_count_step, sample_accept && count_open,
        (state_reg == S_IDLE) && (sample_count_reg == $past(sample_count_reg) + 16'd1),
        "sample inside a window did not just count")
    `PRM_ASSERT_NEXT(a_peak_clear, (state_reg == S_EST_ACC) && ch_reg,
        (vpeak_reg == '0) && (cpeak_reg == '0), "peaks not cleared at window close")
    `PRM_ASSERT_NOW(a_report_from_emit, $rose(report_valid_reg),
        $past(state_reg) == S_EMIT, "report raised outside the emit step")
    `PRM_ASSERT_NOW(a_div_count, state_reg == S_DIV_RUN,
        div_cnt_reg < DIV_CNT_W'(DVD_W), "divider ran past its width")

endmodule
